### hw/rtl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp delay queue package
// Shared item types, field widths and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

   // Fixed field widths of the channels.
   localparam int TIME_FIELD_W = 48;
   localparam int FILL_W       = 7;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT     = 16;
   localparam int TIME_BITS_DEFAULT = 48;

   // Entries in the command queue between front and back.
   localparam int CMDQ_DEPTH = 2;

   // One input beat.
   typedef struct packed {
      logic                    action;
      logic                    activate;
      logic [TIME_FIELD_W-1:0] current_time;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic                    finished;
      logic                    has_entry;
      logic [TIME_FIELD_W-1:0] elapsed;
      logic                    last;
      logic                    overflow;
      logic [FILL_W-1:0]       fill;
   } rsp_type;

   // A classified command handed from front to back.
   typedef struct packed {
      logic                    clear;
      logic                    push;
      logic [TIME_FIELD_W-1:0] stamp;
   } cmd_type;

endpackage : tdq_pkg

`default_nettype wire

### hw/rtl/tdq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read port whose data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : tdq_ram

`default_nettype wire

### hw/rtl/tdq_front.sv
// ----------------------------------------------------------------------------
// Timestamp delay queue front end
// Accepts input beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire tdq_pkg::req_type req_data,
   output      logic             cmd_valid,
   output      tdq_pkg::cmd_type cmd,
   input  wire logic             cmd_pop
);

   localparam int PTR_W = (tdq_pkg::CMDQ_DEPTH > 1) ? $clog2(tdq_pkg::CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(tdq_pkg::CMDQ_DEPTH + 1);

   tdq_pkg::cmd_type q_ff [tdq_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   tdq_pkg::cmd_type cmd_in;
   logic             push;
   logic             pop;

   // Classify the beat: a clear ignores activate.
   always_comb begin
      cmd_in.clear = req_data.action;
      cmd_in.push  = ~req_data.action & req_data.activate;
      cmd_in.stamp = req_data.current_time;
   end

   assign req_stall = (cnt_ff == CNT_W'(tdq_pkg::CMDQ_DEPTH));
   assign push      = req_valid & ~req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_pop & cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tdq_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tdq_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule : tdq_front

`default_nettype wire

### hw/rtl/tdq_back.sv
// ----------------------------------------------------------------------------
// Timestamp delay queue back end
// Runs commands against the timestamp ring and streams result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_back #(
   parameter int DEPTH     = tdq_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = tdq_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   input  wire tdq_pkg::cmd_type                 cmd,
   output      logic                             cmd_pop,
   input  wire logic [tdq_pkg::TIME_FIELD_W-1:0] delay,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      tdq_pkg::rsp_type                 rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (TIME_BITS > tdq_pkg::TIME_FIELD_W) ? TIME_BITS
                                                               : tdq_pkg::TIME_FIELD_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HREAD = 3'd1;
   localparam logic [2:0] S_HCMP  = 3'd2;
   localparam logic [2:0] S_LOUT  = 3'd3;
   localparam logic [2:0] S_EMPTY = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 fin_ff, fin_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tdq_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_pos;
   logic [SUM_W-1:0]     wr_sum;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [TIME_BITS-1:0] rd_data;
   logic [TIME_BITS-1:0] diff;
   logic                 due;
   logic                 out_free;
   logic                 is_last;
   logic [IDX_W-1:0]     head_inc;
   logic [IDX_W-1:0]     pos_inc;
   logic [IDX_W-1:0]     head_new;
   logic [CNT_W-1:0]     count_new;

   tdq_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_pos),
      .wr_data (TIME_BITS'(cmd.stamp)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Ring arithmetic: tail slot and wrapped increments.
   assign wr_sum   = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_pos   = (wr_sum >= SUM_W'(DEPTH)) ? IDX_W'(wr_sum - SUM_W'(DEPTH))
                                               : IDX_W'(wr_sum);
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign pos_inc  = (pos_ff == IDX_W'(DEPTH - 1)) ? '0 : pos_ff + 1'b1;

   // Elapsed time of the entry just read, and the due check on the oldest one.
   assign diff      = now_ff - rd_data;
   assign due       = CMP_W'(diff) >= CMP_W'(delay);
   assign head_new  = due ? head_inc : head_ff;
   assign count_new = due ? count_ff - 1'b1 : count_ff;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign is_last  = (idx_ff + 1'b1 == count_ff);
   assign cmd_pop  = (state_ff == S_IDLE) & cmd_valid;
   assign wr_en    = cmd_pop & ~cmd.clear & cmd.push & (count_ff != CNT_W'(DEPTH));

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      fin_in       = fin_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               now_in = TIME_BITS'(cmd.stamp);
               fin_in = 1'b0;
               ovf_in = 1'b0;
               if (cmd.clear) begin
                  head_in  = '0;
                  count_in = '0;
                  state_in = S_EMPTY;
               end else begin
                  if (cmd.push) begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        ovf_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  state_in = S_HREAD;
               end
            end
         end

         // Fetch the oldest entry; a push made last cycle is now in place.
         S_HREAD: begin
            if (count_ff == '0) begin
               state_in = S_EMPTY;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = S_HCMP;
            end
         end

         // Retire the oldest entry if its delay has passed, then list the rest or mark empty.
         S_HCMP: begin
            head_in  = head_new;
            count_in = count_new;
            fin_in   = due;
            if (count_new == '0) begin
               state_in = S_EMPTY;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_new;
               pos_in   = head_new;
               idx_in   = '0;
               state_in = S_LOUT;
            end
         end

         // One beat per remaining entry, oldest first.
         S_LOUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.finished  = fin_ff;
               rsp_data_in.has_entry = 1'b1;
               rsp_data_in.elapsed   = tdq_pkg::TIME_FIELD_W'(diff);
               rsp_data_in.last      = is_last;
               rsp_data_in.overflow  = ovf_ff;
               rsp_data_in.fill      = tdq_pkg::FILL_W'(count_ff);
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_inc;
                  pos_in  = pos_inc;
                  idx_in  = idx_ff + 1'b1;
               end
            end
         end

         // A single marker beat when no entry remains.
         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.finished  = fin_ff;
               rsp_data_in.has_entry = 1'b0;
               rsp_data_in.elapsed   = '0;
               rsp_data_in.last      = 1'b1;
               rsp_data_in.overflow  = ovf_ff;
               rsp_data_in.fill      = '0;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the output beat.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      fin_ff      <= fin_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : tdq_back

`default_nettype wire

### hw/rtl/timestamp_delay_queue.sv
// A tick beat waits in the command queue; the back end reads the oldest entry,
// retires it if its delay has passed, then gives one result beat per cycle over
// the remaining entries while the output is not stalled, one RAM read each.
// A clear, or a tick that leaves the queue empty, gives a single marker beat.
// A two-entry command queue lets beats be accepted while the back end works.
// Synchronous reset empties the queue and clears the delay register to zero.
// ----------------------------------------------------------------------------
// Timestamp delay queue
// FIFO of start times that retires the oldest once the configured delay passes.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_delay_queue #(
   parameter int DEPTH     = tdq_pkg::DEPTH_DEFAULT,
   parameter int TIME_BITS = tdq_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire tdq_pkg::req_type                 req_data,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      tdq_pkg::rsp_type                 rsp_data,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [tdq_pkg::TIME_FIELD_W-1:0] csr_data
);

   logic [tdq_pkg::TIME_FIELD_W-1:0] delay_ff, delay_in;
   logic                             cmd_valid;
   tdq_pkg::cmd_type                 cmd;
   logic                             cmd_pop;

   // Delay register, always ready for a write beat.
   assign csr_ready = 1'b1;
   assign delay_in  = (csr_valid && csr_ready) ? csr_data : delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else begin
         delay_ff <= delay_in;
      end
   end

   tdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tdq_back #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .delay     (delay_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule : timestamp_delay_queue

`default_nettype wire
